// File: rtl/ip_prefix_list_matcher_defines.svh
// Assertion macros for the IP prefix list matcher checker.
// Depends on nothing; included by the checker file only.
`ifndef IP_PREFIX_LIST_MATCHER_DEFINES_SVH
`define IP_PREFIX_LIST_MATCHER_DEFINES_SVH

// Assert a property that is ignored while reset is high.
`define IPLM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assert a property that is checked during reset as well.
`define IPLM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/iplm_pkg.sv
// Shared types, constants and the prefix compare function of the prefix list matcher.
// No dependencies; used by the cell, the top level and the checker.
`default_nettype none

package iplm_pkg;

  localparam int ADDR_BITS = 128;
  localparam logic [7:0] PLEN_MAX = 8'd128;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  version;
    logic [7:0]  prefix_length;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } in_t;

  typedef struct packed {
    logic matched;
    logic list_nonempty;
    logic overflow;
  } out_t;

  typedef struct packed {
    logic [3:0]           version;
    logic [7:0]           prefix;
    logic [ADDR_BITS-1:0] addr;
  } pfx_t;

  typedef struct packed {
    logic match;
    pfx_t pfx;
  } tok_t;

  function automatic logic [7:0] sat_prefix(logic [7:0] plen);
    return (plen > PLEN_MAX) ? PLEN_MAX : plen;
  endfunction

  function automatic logic prefix_hit(pfx_t e, pfx_t q);
    logic [7:0]           n;
    logic [ADDR_BITS-1:0] mask;
    logic [ADDR_BITS-1:0] diff;
    n = (q.prefix < e.prefix) ? q.prefix : e.prefix;
    mask = {ADDR_BITS{1'b1}} << (PLEN_MAX - n);
    diff = (e.addr ^ q.addr) & mask;
    return (e.version == q.version) && (diff == '0);
  endfunction

endpackage

`default_nettype wire

// File: rtl/iplm_cell.sv
// One cell of the prefix chain: holds one list entry and compares a passing query.
// Depends on iplm_pkg.
`default_nettype none

module iplm_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           shift,
  input  wire iplm_pkg::pfx_t entry_in,
  output iplm_pkg::pfx_t      entry,
  input  wire logic           occupied,
  input  wire logic           tok_in_valid,
  input  wire iplm_pkg::tok_t tok_in,
  output logic                tok_valid,
  output iplm_pkg::tok_t      tok
);

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else begin
      tok_valid <= tok_in_valid;
    end
  end

  // accumulate hit and advance the query
  always_ff @(posedge clk) begin
    tok.pfx   <= tok_in.pfx;
    tok.match <= tok_in.match | (occupied & iplm_pkg::prefix_hit(entry, tok_in.pfx));
  end

endmodule

`default_nettype wire

// File: rtl/ip_prefix_list_matcher.sv
// Top level of the IP prefix list matcher: control, entry count and the cell chain.
// Depends on iplm_pkg and iplm_cell.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one operation per transfer:
//   clear the list, append one prefix, or query one address with its prefix length.
//   Output channel out_valid/out_ready/out_data returns one result per input.
//   Entries live in a chain of LIST_DEPTH cells; an append to a list that is not full shifts the chain by one.
//   A query walks the chain one cell per cycle, so a query result shows up once it
//   has passed the last cell, and the next item is taken after that.
//   Clear, append and unused codes complete in one cycle: their result is valid the
//   cycle after the transfer and a new item may be taken every cycle.
//   A stalled receiver holds the result in the output register; one more result
//   waits in a pending register, and in_ready drops while it is occupied.
//   Reset empties the list and drops any result or query in flight; entry storage
//   itself is not cleared, and no clearing pass is needed.
`default_nettype none

module ip_prefix_list_matcher #(
  parameter int LIST_DEPTH = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire iplm_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output iplm_pkg::out_t     out_data
);

  localparam int CW = $clog2(LIST_DEPTH + 1);

  logic [CW-1:0]  count;
  logic           q_active;
  logic           pend_valid;
  iplm_pkg::out_t pend_data;

  logic           accept;
  logic           full;
  logic           shift;
  logic           out_free;
  logic           res_valid;
  iplm_pkg::out_t res_data;
  iplm_pkg::pfx_t new_entry;

  iplm_pkg::pfx_t stored  [0:LIST_DEPTH-1];
  iplm_pkg::pfx_t cell_in [0:LIST_DEPTH-1];
  logic           tok_valid [0:LIST_DEPTH];
  iplm_pkg::tok_t tok       [0:LIST_DEPTH];

  assign in_ready  = !q_active && !pend_valid;
  assign accept    = in_valid && in_ready;
  assign full      = (count == CW'(LIST_DEPTH));
  assign out_free  = !out_valid || out_ready;

  assign new_entry.version = in_data.version;
  assign new_entry.prefix  = iplm_pkg::sat_prefix(in_data.prefix_length);
  assign new_entry.addr    = {in_data.addr_high, in_data.addr_low};

  assign shift = accept && (in_data.operation == iplm_pkg::OP_APPEND) && !full;

  assign tok_valid[0] = accept && (in_data.operation == iplm_pkg::OP_QUERY);
  assign tok[0].match = 1'b0;
  assign tok[0].pfx   = new_entry;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_in[i] = new_entry;
    end else begin : g_body
      assign cell_in[i] = stored[i-1];
    end

    iplm_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .shift        (shift),
      .entry_in     (cell_in[i]),
      .entry        (stored[i]),
      .occupied     (count > CW'(i)),
      .tok_in_valid (tok_valid[i]),
      .tok_in       (tok[i]),
      .tok_valid    (tok_valid[i+1]),
      .tok          (tok[i+1])
    );
  end

  always_comb begin
    res_valid = 1'b0;
    res_data  = '0;
    if (accept) begin
      unique case (iplm_pkg::op_t'(in_data.operation))
        iplm_pkg::OP_CLEAR: begin
          res_valid = 1'b1;
        end
        iplm_pkg::OP_APPEND: begin
          res_valid              = 1'b1;
          res_data.list_nonempty = 1'b1;
          res_data.overflow      = full;
        end
        iplm_pkg::OP_QUERY: begin
          res_valid = 1'b0;
        end
        default: begin
          res_valid              = 1'b1;
          res_data.list_nonempty = (count != '0);
        end
      endcase
    end else if (tok_valid[LIST_DEPTH]) begin
      res_valid              = 1'b1;
      res_data.matched       = tok[LIST_DEPTH].match;
      res_data.list_nonempty = (count != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept && (in_data.operation == iplm_pkg::OP_CLEAR)) begin
      count <= '0;
    end else if (shift) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_active <= 1'b0;
    end else if (tok_valid[0]) begin
      q_active <= 1'b1;
    end else if (tok_valid[LIST_DEPTH]) begin
      q_active <= 1'b0;
    end
  end

  // hold a result that finds the output register busy
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (pend_valid && out_free) begin
      pend_valid <= 1'b0;
    end else if (res_valid && !out_free) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && !out_free) begin
      pend_data <= res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pend_valid || res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= pend_valid ? pend_data : res_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/iplm_checker.sv
// Port-level checks on the IP prefix list matcher and the bind that attaches them.
// Depends on iplm_pkg, ip_prefix_list_matcher and ip_prefix_list_matcher_defines.svh.
`default_nettype none
`include "ip_prefix_list_matcher_defines.svh"

module iplm_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire iplm_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire iplm_pkg::out_t out_data
);

  logic stall;
  logic out_free;
  logic clear_xfer;
  logic append_xfer;
  logic append_ok;

  assign stall       = out_valid && !out_ready;
  assign out_free    = !out_valid || out_ready;
  assign clear_xfer  = in_valid && in_ready && out_free &&
                       (in_data.operation == iplm_pkg::OP_CLEAR);
  assign append_xfer = in_valid && in_ready && out_free &&
                       (in_data.operation == iplm_pkg::OP_APPEND);
  assign append_ok   = !out_data.matched && out_data.list_nonempty;

  `IPLM_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !out_valid, "output valid after reset")

  `IPLM_ASSERT(a_out_hold, clk, rst, stall |=> out_valid && $stable(out_data), "stalled result changed")

  `IPLM_ASSERT(a_clear_result, clk, rst, clear_xfer |=> out_valid && (out_data == '0), "clear result wrong")

  `IPLM_ASSERT(a_append_result, clk, rst, append_xfer |=> out_valid && append_ok, "append result wrong")

endmodule

bind ip_prefix_list_matcher iplm_checker u_iplm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
